>>> hw/rtl/wola_pkg.sv
package wola_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] CFG_FFT_SIZE = 2'd0;
	localparam logic [1:0] CFG_HOP      = 2'd1;
	localparam logic [1:0] CFG_FRAMES   = 2'd2;
	localparam logic [1:0] CFG_FLOOR    = 2'd3;

	// Operation codes of an input item
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Width of an output position (frame start plus offset)
	localparam int PW = 28;
	// Quotient bits produced by the normalizing divider
	localparam int DIV_STEPS = 24;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_ACC,
		S_WB,
		S_DIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic mul;
		logic acc;
		logic wb;
		logic div_step;
		logic out_load;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic restart;
		logic clear_done;
		logic is_sample;
		logic emit;
		logic under;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

>>> hw/rtl/wola_ctrl.sv
module wola_ctrl import wola_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  status_t status,
	output logic    in_stall,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		state_d  = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (status.is_sample) begin
						state_d = S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_WB;
			end
			S_WB: begin
				cmd.wb = 1'b1;
				priority if (status.emit && !status.under) begin
					state_d = S_DIV;
				end else if (status.emit) begin
					state_d = S_OUT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		// a signal restart wipes the rings again
		if (status.restart) begin
			state_d = S_CLEAR;
		end
	end

endmodule

>>> hw/rtl/wola_dp.sv
module wola_dp import wola_pkg::*; #(
	parameter int MAX_FFT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               operation,
	input  logic [9:0]         window_index,
	input  logic signed [16:0] window_value,
	input  logic signed [23:0] frame_sample,
	input  logic               out_stall,
	input  cmd_t               cmd,
	output status_t            status,
	output logic               out_valid,
	output logic signed [23:0] audio_sample,
	output logic               last,
	output logic               underflow
);

	localparam int AW = $clog2(MAX_FFT);
	localparam int CW = ((AW > 11) ? AW : 11) + 1;
	localparam logic [AW:0] DEPTH = (AW + 1)'(MAX_FFT);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FFT - 1);

	// configuration
	logic [10:0] fft_size_q, hop_q;
	logic [15:0] frames_q;
	logic [19:0] floor_q;
	logic        restart;

	assign restart = cfg_wr_en && (cfg_index == CFG_FFT_SIZE || cfg_index == CFG_HOP ||
		cfg_index == CFG_FRAMES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fft_size_q <= 11'd1024;
			hop_q      <= 11'd256;
			frames_q   <= 16'd1;
			floor_q    <= 20'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FFT_SIZE: fft_size_q <= cfg_data[10:0];
				CFG_HOP:      hop_q      <= cfg_data[10:0];
				CFG_FRAMES:   frames_q   <= cfg_data[15:0];
				CFG_FLOOR:    floor_q    <= cfg_data;
				default:      floor_q    <= floor_q;
			endcase
		end
	end

	// derived geometry, settles during the clearing pass
	logic [10:0]   fft_cl, hop_pre, hop_cl;
	logic [15:0]   frames_cl;
	logic [10:0]   fft_s1, hop_s1;
	logic [15:0]   frames_s1;
	logic [PW-1:0] span_s2, end_s3;
	logic [10:0]   pad_s2, pad_s3, fft_s2;

	always_comb begin
		if (fft_size_q < 11'd2) begin
			fft_cl = 11'd2;
		end else if (32'(fft_size_q) > MAX_FFT) begin
			fft_cl = 11'(MAX_FFT);
		end else begin
			fft_cl = fft_size_q;
		end
		hop_pre   = (hop_q == 11'd0) ? 11'd1 : hop_q;
		hop_cl    = (hop_pre > fft_cl) ? fft_cl : hop_pre;
		frames_cl = (frames_q == 16'd0) ? 16'd1 : frames_q;
	end

	always_ff @(posedge clk) begin
		fft_s1    <= fft_cl;
		hop_s1    <= hop_cl;
		frames_s1 <= frames_cl;
		span_s2   <= PW'(frames_s1 - 16'd1) * PW'(hop_s1);
		pad_s2    <= (fft_s1 - hop_s1) >> 1;
		fft_s2    <= fft_s1;
		end_s3    <= span_s2 + PW'(fft_s2) - PW'(pad_s2);
		pad_s3    <= pad_s2;
	end

	// position counters
	logic [AW-1:0] offset_q, sbase_q, slot, clr_q;
	logic [15:0]   frame_q;
	logic [PW-1:0] base_q, pos;
	logic [AW:0]   slot_sum, sb_sum;
	logic          last_frame, final_pos, off_wrap, frame_wrap, clear_done;

	always_comb begin
		slot_sum   = (AW + 1)'(sbase_q) + (AW + 1)'(offset_q);
		slot       = AW'((slot_sum >= DEPTH) ? slot_sum - DEPTH : slot_sum);
		sb_sum     = (AW + 1)'(sbase_q) + (AW + 1)'(hop_s1);
		pos        = base_q + PW'(offset_q);
		last_frame = (17'(frame_q) + 17'd1) >= 17'(frames_s1);
		final_pos  = last_frame || (CW'(offset_q) < CW'(hop_s1));
		off_wrap   = (CW'(offset_q) + CW'(1)) >= CW'(fft_s1);
		frame_wrap = last_frame;
		clear_done = (clr_q == LAST_ADDR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			frame_q  <= '0;
			base_q   <= '0;
			sbase_q  <= '0;
		end else if (restart) begin
			offset_q <= '0;
			frame_q  <= '0;
			base_q   <= '0;
			sbase_q  <= '0;
		end else if (cmd.wb) begin
			if (!off_wrap) begin
				offset_q <= offset_q + AW'(1);
			end else begin
				offset_q <= '0;
				if (frame_wrap) begin
					frame_q <= '0;
					base_q  <= '0;
					sbase_q <= '0;
				end else begin
					frame_q <= frame_q + 16'd1;
					base_q  <= base_q + PW'(hop_s1);
					sbase_q <= AW'((sb_sum >= DEPTH) ? sb_sum - DEPTH : sb_sum);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (restart) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clear_done ? '0 : clr_q + AW'(1);
		end
	end

	// window store
	logic signed [16:0] win_mem [MAX_FFT];
	logic signed [16:0] win_rd_q;
	logic               win_ok;

	assign win_ok = 32'(window_index) < MAX_FFT;

	always_ff @(posedge clk) begin
		if (cmd.accept && operation == OP_LOAD) begin
			if (win_ok) begin
				win_mem[AW'(window_index)] <= window_value;
			end
		end else if (cmd.accept) begin
			win_rd_q <= win_mem[offset_q];
		end
	end

	// overlap and envelope rings
	logic [47:0]   acc_mem [MAX_FFT];
	logic [39:0]   env_mem [MAX_FFT];
	logic [47:0]   acc_rd_q, acc_q;
	logic [39:0]   env_rd_q, env_q;
	logic          final_q;
	logic          ring_we;
	logic [AW-1:0] ring_addr;
	logic [47:0]   acc_wd;
	logic [39:0]   env_wd;

	always_comb begin
		ring_we   = cmd.clear || cmd.wb;
		ring_addr = cmd.clear ? clr_q : slot;
		acc_wd    = (cmd.clear || final_q) ? '0 : acc_q;
		env_wd    = (cmd.clear || final_q) ? '0 : env_q;
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			acc_mem[ring_addr] <= acc_wd;
			env_mem[ring_addr] <= env_wd;
		end else if (cmd.accept) begin
			acc_rd_q <= acc_mem[slot];
			env_rd_q <= env_mem[slot];
		end
	end

	// multiply and accumulate
	logic signed [23:0] sample_q;
	logic signed [40:0] prod_q;
	logic [32:0]        wsq_q;
	logic signed [33:0] wsq_full;
	logic signed [48:0] acc_sum;
	logic [40:0]        env_sum;
	logic [47:0]        acc_sat;
	logic [39:0]        env_sat;
	logic               emit_q, lastpos_q, under_q;

	always_comb begin
		wsq_full = win_rd_q * win_rd_q;
		acc_sum  = 49'($signed(acc_rd_q)) + 49'(prod_q);
		env_sum  = {1'b0, env_rd_q} + 41'(wsq_q);
		if (acc_sum[48] != acc_sum[47]) begin
			acc_sat = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			acc_sat = acc_sum[47:0];
		end
		env_sat = env_sum[40] ? {40{1'b1}} : env_sum[39:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= frame_sample;
		end
		if (cmd.mul) begin
			prod_q <= sample_q * win_rd_q;
			wsq_q  <= wsq_full[32:0];
		end
		if (cmd.acc) begin
			acc_q     <= acc_sat;
			env_q     <= env_sat;
			final_q   <= final_pos;
			emit_q    <= final_pos && pos >= PW'(pad_s3) && pos < end_s3;
			lastpos_q <= pos == end_s3 - PW'(1);
			under_q   <= env_sat <= 40'(floor_q);
		end
	end

	// restoring divider: one quotient bit a step
	logic [47:0] mag;
	logic [39:0] rem_q;
	logic [23:0] dd_q, quo_q;
	logic [4:0]  cnt_q;
	logic        neg_q, ovf_q;
	logic [40:0] trial;
	logic        ge;

	always_comb begin
		mag   = acc_q[47] ? (~acc_q + 48'd1) : acc_q;
		trial = {rem_q, dd_q[23]};
		ge    = trial >= {1'b0, env_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			neg_q <= acc_q[47];
			ovf_q <= {1'b0, mag[47:9]} >= env_q;
			rem_q <= {1'b0, mag[47:9]};
			dd_q  <= {mag[8:0], 15'd0};
			quo_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? 40'(trial - {1'b0, env_q}) : trial[39:0];
			quo_q <= {quo_q[22:0], ge};
			dd_q  <= {dd_q[22:0], 1'b0};
			cnt_q <= cnt_q + 5'd1;
		end
	end

	// saturate and register the result
	logic [23:0] audio_d;

	always_comb begin
		if (under_q) begin
			audio_d = '0;
		end else if (neg_q) begin
			audio_d = (ovf_q || quo_q > 24'h800000) ? 24'h800000 : (~quo_q + 24'd1);
		end else begin
			audio_d = (ovf_q || quo_q > 24'h7FFFFF) ? 24'h7FFFFF : quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			audio_sample <= $signed(audio_d);
			last         <= lastpos_q;
			underflow    <= under_q;
		end
	end

	always_comb begin
		status.restart    = restart;
		status.clear_done = clear_done;
		status.is_sample  = (operation == OP_SAMPLE);
		status.emit       = emit_q;
		status.under      = under_q;
		status.div_done   = (cnt_q == 5'(DIV_STEPS - 1));
		status.out_free   = !out_valid || !out_stall;
	end

endmodule

>>> hw/rtl/windowed_overlap_add_normalize.sv
// Weighted overlap-add back end of an inverse STFT. Load the window first with
// operation 0 items (one cycle each), then send frame samples in order, frame by
// frame, with operation 1. Each sample is weighted by its window coefficient and
// summed into a 48-bit overlap ring; the squared coefficient goes into a 40-bit
// envelope ring. Once a position can no longer be reached by a later frame it is
// normalized (overlap << 15 / envelope, saturated to Q1.22) and, if it lies in the
// centre-trimmed span, transferred out; last marks the final trimmed sample and
// underflow marks an envelope at or below envelope_floor (sample forced to 0).
// A sample holds in_stall high while it passes multiply, accumulate and write back;
// an underflow result then goes straight out, a normalized result first through the
// restoring divider, which yields one of 24 quotient bits per cycle. A finished result
// waits in the output register, so the next item is taken while it is stalled. After
// reset and after every write of the frame size, hop or frame count register the block
// clears both rings, one entry per cycle, with in_stall high; envelope_floor writes
// take effect at once.
module windowed_overlap_add_normalize import wola_pkg::*; #(
	parameter int MAX_FFT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [9:0]         window_index,
	input  logic signed [16:0] window_value,
	input  logic signed [23:0] frame_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] audio_sample,
	output logic               last,
	output logic               underflow
);

	cmd_t    cmd;
	status_t status;

	// sequencer: clear pass, accept, multiply, accumulate, write back, divide, output
	wola_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// rings, window store, position counters, divider and output register
	wola_dp #(
		.MAX_FFT (MAX_FFT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.window_index (window_index),
		.window_value (window_value),
		.frame_sample (frame_sample),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.audio_sample (audio_sample),
		.last         (last),
		.underflow    (underflow)
	);

endmodule

>>> hw/rtl/wola_chk.sv
module wola_chk import wola_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_wr_en,
	input logic [1:0]         cfg_index,
	input logic [19:0]        cfg_data,
	input logic               in_valid,
	input logic               in_stall,
	input logic               operation,
	input logic [9:0]         window_index,
	input logic signed [16:0] window_value,
	input logic signed [23:0] frame_sample,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [23:0] audio_sample,
	input logic               last,
	input logic               underflow
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(audio_sample) && $stable(last)
			&& $stable(underflow))
		else $error("stalled result changed");

	// an underflowed result carries a zero sample
	a_under_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && underflow |-> audio_sample == 24'sd0)
		else $error("underflow with nonzero sample");

	// a restart write starts the clearing pass
	a_restart_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en && (cfg_index == CFG_FFT_SIZE || cfg_index == CFG_HOP ||
			cfg_index == CFG_FRAMES) |=> in_stall)
		else $error("no clearing pass after restart");

	// a window load leaves in_stall low for the next item
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == OP_LOAD && !cfg_wr_en |=> !in_stall)
		else $error("window load stalled");

	// a frame sample stalls the input once it is accepted
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && operation == OP_SAMPLE |=> in_stall)
		else $error("sample accepted back to back");

endmodule

bind windowed_overlap_add_normalize wola_chk u_wola_chk (.*);

>>> sim/tb_windowed_overlap_add_normalize.sv
module tb_windowed_overlap_add_normalize;
	import wola_pkg::*;

	localparam int RING = 1024;
	localparam longint OVL_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint OVL_MIN = -OVL_MAX - 1;
	localparam longint unsigned ENV_MAX = 64'hFF_FFFF_FFFF;

	typedef struct {
		logic        op;
		logic [9:0]  idx;
		logic [16:0] coef;
		logic [23:0] smp;
	} wola_item_t;

	typedef struct {
		logic [23:0] audio;
		logic        fin;
		logic        under;
	} audio_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = CFG_FFT_SIZE;
	logic [19:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = OP_LOAD;
	logic [9:0] window_index = '0;
	logic signed [16:0] window_value = '0;
	logic signed [23:0] frame_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [23:0] audio_sample;
	logic last;
	logic underflow;

	windowed_overlap_add_normalize DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .window_index(window_index),
		.window_value(window_value), .frame_sample(frame_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.audio_sample(audio_sample), .last(last), .underflow(underflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the block: window, both rings, frame position, registers
	logic signed [16:0] win_mem [RING];
	longint ovl_ring [RING];
	longint unsigned env_ring [RING];
	int unsigned frame_num, frame_off;
	int unsigned reg_fft = 1024, reg_hop = 256, reg_frames = 1, reg_floor = 1;

	wola_item_t pending_items[$];
	audio_out_t expected_audio[$];
	wola_item_t cur_item;
	logic in_fire = 1'b0;
	int mismatches = 0;
	int item_total = 0;
	int unsigned cyc = 0;

	function automatic void clear_signal();
		for (int k = 0; k < RING; k++) begin
			ovl_ring[k] = 0;
			env_ring[k] = 0;
		end
		frame_num = 0;
		frame_off = 0;
	endfunction

	// Effective (clamped) register values
	function automatic int unsigned eff_fft();
		if (reg_fft < 2) return 2;
		if (reg_fft > RING) return RING;
		return reg_fft;
	endfunction

	function automatic int unsigned eff_hop();
		int unsigned f;
		f = eff_fft();
		if (reg_hop < 1) return 1;
		if (reg_hop > f) return f;
		return reg_hop;
	endfunction

	function automatic int unsigned eff_frames();
		return (reg_frames < 1) ? 1 : reg_frames;
	endfunction

	// Weight one sample into the rings and queue a result for a final position in the trimmed span
	function automatic void overlap_add_sample(logic signed [23:0] smp);
		int unsigned fft, hop, frames, pad, out_size, pos, slot;
		longint w, acc, quo;
		longint unsigned env, mag;
		logic [63:0] q;
		audio_out_t r;
		fft = eff_fft();
		hop = eff_hop();
		frames = eff_frames();
		pad = (fft - hop) / 2;
		out_size = (frames - 1) * hop + fft;
		pos = frame_num * hop + frame_off;
		slot = pos % RING;
		w = win_mem[frame_off % RING];
		acc = ovl_ring[slot] + longint'(smp) * w;
		if (acc > OVL_MAX) acc = OVL_MAX;
		if (acc < OVL_MIN) acc = OVL_MIN;
		env = env_ring[slot] + longint'(w * w);
		if (env > ENV_MAX) env = ENV_MAX;
		ovl_ring[slot] = acc;
		env_ring[slot] = env;
		if (frame_num + 1 >= frames || frame_off < hop) begin
			if (pos >= pad && pos < out_size - pad) begin
				quo = 0;
				r.under = (env <= reg_floor);
				if (!r.under) begin
					mag = (acc < 0) ? -acc : acc;
					q = (mag << 15) / env;
					if (acc < 0) quo = (q > 64'h80_0000) ? -64'sh80_0000 : -longint'(q);
					else quo = (q > 64'h7F_FFFF) ? 64'sh7F_FFFF : longint'(q);
				end
				r.audio = quo[23:0];
				r.fin = (pos == out_size - pad - 1);
				expected_audio.push_back(r);
			end
			ovl_ring[slot] = 0;
			env_ring[slot] = 0;
		end
		frame_off++;
		if (frame_off >= fft) begin
			frame_off = 0;
			frame_num++;
			if (frame_num >= frames) frame_num = 0;
		end
	endfunction

	// Random idling, except in one quiet stretch
	function automatic bit idle_ok();
		return !(cyc >= 6000 && cyc < 12000);
	endfunction

	// Driver: advance to the next pending item after a transfer or from idle
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (pending_items.size() > 0 && !(idle_ok() && $urandom_range(99) < 13)) begin
				cur_item = pending_items.pop_front();
				operation <= cur_item.op;
				window_index <= cur_item.idx;
				window_value <= cur_item.coef;
				frame_sample <= cur_item.smp;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Predict on each accepted input transfer
	always @(posedge clk) begin
		in_fire <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			if (operation == OP_LOAD) win_mem[window_index] = window_value;
			else overlap_add_sample(frame_sample);
		end
	end

	// Receiver: one long hold-off so the block backs up, otherwise random stalls
	int unsigned hold_cnt = 0;
	bit hold_done = 1'b0;
	always @(negedge clk) begin
		cyc++;
		if (!hold_done && cyc >= 5000 && out_valid) begin
			hold_cnt = 600;
			hold_done = 1'b1;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_ok() && ($urandom_range(99) < 13);
		end
	end

	// Monitor: check each output transfer against the oldest prediction
	always @(posedge clk) begin
		audio_out_t e;
		if (out_valid && !out_stall) begin
			if (expected_audio.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output: audio=%0d last=%0b underflow=%0b",
						audio_sample, last, underflow);
			end else begin
				e = expected_audio.pop_front();
				if (audio_sample !== e.audio || last !== e.fin || underflow !== e.under) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp audio=%0d last=%0b uf=%0b, got audio=%0d last=%0b uf=%0b",
							$signed(e.audio), e.fin, e.under, audio_sample, last, underflow);
				end
			end
		end
	end

	task automatic push_item(logic op, logic [9:0] idx, logic [16:0] coef, logic [23:0] smp);
		wola_item_t it;
		it.op = op;
		it.idx = idx;
		it.coef = coef;
		it.smp = smp;
		pending_items.push_back(it);
		item_total++;
	endtask

	// Let everything drain; extra cycles cover a sample that emits nothing
	task automatic wait_drained();
		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_audio.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [19:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_FFT_SIZE: begin reg_fft = val[10:0]; clear_signal(); end
			CFG_HOP:      begin reg_hop = val[10:0]; clear_signal(); end
			CFG_FRAMES:   begin reg_frames = val[15:0]; clear_signal(); end
			CFG_FLOOR:    reg_floor = val;
		endcase
	endtask

	task automatic setup(int unsigned fft, int unsigned hop, int unsigned frames, int unsigned flr);
		write_reg(CFG_FFT_SIZE, 20'(fft));
		write_reg(CFG_HOP, 20'(hop));
		write_reg(CFG_FRAMES, 20'(frames));
		write_reg(CFG_FLOOR, 20'(flr));
	endtask

	function automatic logic [16:0] rand_coef();
		int unsigned k;
		k = $urandom_range(9);
		if (k == 0) return '0;
		if (k == 1) return 17'($signed($urandom_range(8)) - 4);
		return 17'($urandom);
	endfunction

	function automatic logic [23:0] rand_sample();
		int unsigned k;
		k = $urandom_range(15);
		if (k == 0) return 24'h7F_FFFF;
		if (k == 1) return 24'h80_0000;
		return 24'($urandom);
	endfunction

	task automatic load_window(int unsigned n);
		for (int unsigned k = 0; k < n; k++)
			push_item(OP_LOAD, 10'(k), rand_coef(), 24'($urandom));
	endtask

	task automatic send_samples(int unsigned n);
		for (int unsigned k = 0; k < n; k++) begin
			// drop an occasional stray window load into the stream
			if ($urandom_range(31) == 0)
				push_item(OP_LOAD, 10'($urandom_range(RING - 1)), rand_coef(), 24'($urandom));
			push_item(OP_SAMPLE, 10'($urandom), 17'($urandom), rand_sample());
		end
	endtask

	initial begin
		int unsigned fft, hop, frames, flr;
		for (int k = 0; k < RING; k++) win_mem[k] = '0;
		clear_signal();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: zero window entry (underflow), extreme coefficients and samples
		setup(4, 2, 3, 0);
		push_item(OP_LOAD, 10'd0, 17'h0_0000, 24'h0);
		push_item(OP_LOAD, 10'd1, 17'h0_0001, 24'hFF_FFFF);
		push_item(OP_LOAD, 10'd2, 17'h1_0000, 24'h0);
		push_item(OP_LOAD, 10'd3, 17'h0_FFFF, 24'h0);
		push_item(OP_SAMPLE, 10'h3FF, 17'h1_FFFF, 24'h7F_FFFF);
		push_item(OP_SAMPLE, 10'd0, 17'd0, 24'h7F_FFFF);
		push_item(OP_SAMPLE, 10'd0, 17'd0, 24'h80_0000);
		push_item(OP_SAMPLE, 10'd0, 17'd0, 24'hFF_FFFF);
		push_item(OP_SAMPLE, 10'd0, 17'd0, 24'h00_0001);
		push_item(OP_SAMPLE, 10'd0, 17'd0, 24'h80_0000);
		push_item(OP_SAMPLE, 10'd0, 17'd0, 24'h7F_FFFF);
		push_item(OP_SAMPLE, 10'd0, 17'd0, 24'h00_0000);
		push_item(OP_SAMPLE, 10'd0, 17'd0, 24'h80_0000);
		push_item(OP_SAMPLE, 10'd0, 17'd0, 24'h80_0000);
		push_item(OP_SAMPLE, 10'd0, 17'd0, 24'h7F_FFFF);
		push_item(OP_SAMPLE, 10'd0, 17'd0, 24'h7F_FFFF);
		wait_drained();

		// Out-of-range registers: fft above range clamps to the ring size
		setup(11'h7FF, 1022, 1, 20'h0_0100);
		load_window(48);
		send_samples(48);
		wait_drained();
		// Hop of zero acts as one
		setup(8, 0, 3, 1);
		load_window(8);
		send_samples(24);
		wait_drained();
		// Largest hop with a frame count of zero
		setup(1024, 1024, 0, 1);
		send_samples(48);
		wait_drained();
		// fft of zero, hop above fft, huge frame count, cut short
		setup(0, 11'h7FF, 16'hFFFF, 0);
		send_samples(40);
		wait_drained();

		// Random signals, mostly small sizes
		while (item_total < 1300) begin
			fft = ($urandom_range(3) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 16);
			hop = $urandom_range(1, fft);
			frames = $urandom_range(1, 8);
			case ($urandom_range(3))
				0: flr = 0;
				1: flr = 20'hF_FFFF;
				default: flr = $urandom_range(1, 1 << 14);
			endcase
			setup(fft, hop, frames, flr);
			load_window(fft);
			send_samples(frames * fft);
			if ($urandom_range(3) == 0) begin
				// change the floor alone and keep going with the same signal stream
				wait_drained();
				write_reg(CFG_FLOOR, 20'($urandom_range(0, 1 << 16)));
				send_samples(frames * fft);
			end
			if ($urandom_range(4) == 0) begin
				// broken sequence: a partial signal left behind by the next restart
				send_samples($urandom_range(1, frames * fft));
			end
			wait_drained();
		end

		if (mismatches == 0 && expected_audio.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#60000000;
		$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/wola_pkg.sv
hw/rtl/wola_ctrl.sv
hw/rtl/wola_dp.sv
hw/rtl/windowed_overlap_add_normalize.sv
hw/rtl/wola_chk.sv
sim/tb_windowed_overlap_add_normalize.sv
